// ===== rtl/quoted_token_splitter_unit_macros.svh =====
// Assertion macros shared by the quoted token splitter RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef QUOTED_TOKEN_SPLITTER_UNIT_MACROS_SVH
`define QUOTED_TOKEN_SPLITTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define QTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qts_pkg.sv =====
// Shared types, codes and helpers for the quoted token splitter.
// No dependencies; used by every module in rtl/.
package qts_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       token_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] delimiter_byte;
      logic       fold_upper;
      logic       quote_mode;
      logic [7:0] escape_byte;
   } cfg_type;

   // Handshake between the lexer stage and the result register.
   typedef struct packed {
      logic    load;
      rsp_type data;
   } out_load_type;

   typedef enum logic [2:0] {
      PH_TOKEN       = 3'b001,
      PH_AFTER_QUOTE = 3'b010,
      PH_SKIP_WS     = 3'b100
   } phase_type;

   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLD      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTE     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE    = 2'd3;

   localparam logic [7:0] DQUOTE        = 8'd34;
   localparam logic [7:0] SQUOTE        = 8'd39;
   localparam logic [7:0] ESCAPE_RESET  = 8'd92;
   localparam logic [7:0] CASE_OFFSET   = 8'd32;
   localparam logic [7:0] LOWER_A       = 8'd97;
   localparam logic [7:0] LOWER_Z       = 8'd122;
   localparam logic [7:0] SPACE         = 8'd32;
   localparam logic [7:0] TAB           = 8'd9;
   localparam logic [7:0] CR            = 8'd13;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == SPACE) || ((b >= TAB) && (b <= CR));
   endfunction

endpackage

// ===== rtl/qts_csr.sv =====
// Configuration registers of the quoted token splitter.
// Depends on qts_pkg.
module qts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [qts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_wdata,
   output qts_pkg::cfg_type                    cfg
);

   qts_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            qts_pkg::CSR_DELIMITER: cfg_in.delimiter_byte = csr_wdata;
            qts_pkg::CSR_FOLD:      cfg_in.fold_upper     = csr_wdata[0];
            qts_pkg::CSR_QUOTE:     cfg_in.quote_mode     = csr_wdata[0];
            qts_pkg::CSR_ESCAPE:    cfg_in.escape_byte    = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_byte <= 8'd0;
         cfg_ff.fold_upper     <= 1'b1;
         cfg_ff.quote_mode     <= 1'b0;
         cfg_ff.escape_byte    <= qts_pkg::ESCAPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/qts_lexer.sv =====
// Input register, lexer state and the per-byte token logic.
// Depends on qts_pkg and quoted_token_splitter_unit_macros.svh.
`include "quoted_token_splitter_unit_macros.svh"

module qts_lexer (
   input  logic                  clock,
   input  logic                  reset,
   input  qts_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  qts_pkg::req_type      req_data,
   input  logic                  out_can_take,
   output qts_pkg::out_load_type out_load
);

   logic               in_valid_ff, in_valid_in;
   qts_pkg::req_type   in_item_ff;
   qts_pkg::phase_type phase_ff, phase_in;
   logic               in_quotes_ff, in_quotes_in;
   logic               esc_ff, esc_in;
   logic [7:0]         open_quote_ff, open_quote_in;

   logic             advance;
   logic             emit;
   qts_pkg::rsp_type res;
   logic [7:0]       b;
   logic             b_ws, b_delim, quoting, take, close_q;

   assign advance   = in_valid_ff & out_can_take;
   assign req_ready = ~in_valid_ff | advance;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~advance);

   assign b       = in_item_ff.in_byte;
   assign b_ws    = qts_pkg::is_ws(b);
   assign b_delim = (cfg.delimiter_byte != 8'd0) && (b == cfg.delimiter_byte);
   assign quoting = cfg.quote_mode & in_quotes_ff;

   always_comb begin
      phase_in      = phase_ff;
      in_quotes_in  = in_quotes_ff;
      esc_in        = esc_ff;
      open_quote_in = open_quote_ff;
      emit          = 1'b0;
      res           = '0;
      take          = 1'b0;
      close_q       = 1'b0;
      if (in_item_ff.line_end) begin
         // line end: close an open token, then back to line start
         emit          = (phase_ff != qts_pkg::PH_AFTER_QUOTE) &&
                         (phase_ff != qts_pkg::PH_SKIP_WS);
         res.token_end = 1'b1;
         phase_in      = qts_pkg::PH_TOKEN;
         in_quotes_in  = 1'b0;
         esc_in        = 1'b0;
         open_quote_in = 8'd0;
      end else begin
         case (phase_ff)
            qts_pkg::PH_AFTER_QUOTE: begin
               if (b_ws || b_delim) phase_in = qts_pkg::PH_SKIP_WS;
               else take = 1'b1;
            end
            qts_pkg::PH_SKIP_WS: take = ~b_ws;
            default:             take = 1'b1;
         endcase
         if (take) begin
            emit = 1'b1;
            if (!quoting && (b_ws || b_delim)) begin
               in_quotes_in  = 1'b0;
               esc_in        = 1'b0;
               phase_in      = qts_pkg::PH_SKIP_WS;
               res.token_end = 1'b1;
            end else begin
               phase_in = qts_pkg::PH_TOKEN;
               if (cfg.quote_mode) begin
                  if (quoting) begin
                     if (esc_ff) begin
                        esc_in = 1'b0;
                     end else if (b == cfg.escape_byte) begin
                        esc_in = 1'b1;
                     end else if (b == open_quote_ff) begin
                        in_quotes_in = 1'b0;
                        close_q      = 1'b1;
                     end
                  end else if (b == qts_pkg::DQUOTE || b == qts_pkg::SQUOTE) begin
                     in_quotes_in  = 1'b1;
                     open_quote_in = b;
                     esc_in        = 1'b0;
                  end
               end
               res.byte_valid = 1'b1;
               res.token_end  = close_q;
               res.out_byte   = (cfg.fold_upper && b >= qts_pkg::LOWER_A &&
                                 b <= qts_pkg::LOWER_Z) ? b - qts_pkg::CASE_OFFSET : b;
               if (close_q) begin
                  esc_in   = 1'b0;
                  phase_in = qts_pkg::PH_AFTER_QUOTE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         phase_ff      <= qts_pkg::PH_TOKEN;
         in_quotes_ff  <= 1'b0;
         esc_ff        <= 1'b0;
         open_quote_ff <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            in_quotes_ff  <= in_quotes_in;
            esc_ff        <= esc_in;
            open_quote_ff <= open_quote_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_data;
   end

   assign out_load.load = advance & emit;
   assign out_load.data = res;

   `QTS_ASSERT_NOW(a_esc_in_span, clock, reset, esc_ff, in_quotes_ff,
      "escape pending outside a quoted span")
   `QTS_ASSERT_NOW(a_after_quote_closed, clock, reset, phase_ff == qts_pkg::PH_AFTER_QUOTE,
      !in_quotes_ff && !esc_ff, "span still open after close quote")
   `QTS_ASSERT_NEXT(a_line_end_clears, clock, reset, advance && in_item_ff.line_end,
      phase_ff == qts_pkg::PH_TOKEN && !in_quotes_ff && open_quote_ff == 8'd0,
      "line end did not return state to line start")
   `QTS_ASSERT_NEXT(a_hold_stalled, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(in_item_ff), "stalled input item lost or changed")

endmodule

// ===== rtl/qts_out_reg.sv =====
// Result register of the quoted token splitter.
// Depends on qts_pkg.
module qts_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  qts_pkg::out_load_type out_load,
   output logic                  out_can_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output qts_pkg::rsp_type      rsp_data
);

   logic             valid_ff, valid_in;
   qts_pkg::rsp_type data_ff;

   assign out_can_take = ~valid_ff | rsp_ready;
   assign valid_in     = out_load.load | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load.load) data_ff <= out_load.data;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/quoted_token_splitter_unit.sv =====
// Quoted token splitter: cuts a byte stream of command lines into tokens,
// one byte per transfer, at a sustained one transfer per clock while rsp_ready
// allows. Each byte is captured in an input register, classified and run
// through the lexer state (phase, open quote, escape) in one short
// combinational step, and any result lands in an output register. A byte
// that ends no token and carries no character (skipped whitespace, a
// swallowed delimiter after a close quote, a line end between tokens) gives
// no response transfer but still passes through the input register.
// Back-pressure on rsp_ready stalls the input register and thus req_ready.
// The csr port writes delimiter_byte, fold_upper, quote_mode and
// escape_byte (indexes 0..3); write only while idle.
// Depends on qts_pkg, qts_csr, qts_lexer and qts_out_reg.
module quoted_token_splitter_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel: one line byte or line end per transfer
   input  logic                              req_valid,
   output logic                              req_ready,
   input  qts_pkg::req_type                  req_data,
   // response channel: token character and/or token end
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output qts_pkg::rsp_type                  rsp_data,
   // configuration write port
   input  logic                              csr_we,
   input  logic [qts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata
);

   qts_pkg::cfg_type      cfg;
   qts_pkg::out_load_type out_load;
   logic                  out_can_take;

   // configuration registers, reset to delimiter none, folding on,
   // quotes off, escape backslash
   qts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register plus the token state machine
   qts_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .out_can_take (out_can_take),
      .out_load     (out_load)
   );

   // result register; frees whenever the consumer takes the transfer
   qts_out_reg u_out (
      .clock        (clock),
      .reset        (reset),
      .out_load     (out_load),
      .out_can_take (out_can_take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
